// ===== hdl/lowest_free_id_allocator_macros.svh =====
// Assertion macros for the lowest-free-ID allocator.
// Needs clk and rst in the scope of each use.
`ifndef LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define LFID_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfid assertion failed");

// next-cycle implication
`define LFID_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfid assertion failed");

`endif

// ===== hdl/lfid_pkg.sv =====
// Shared constants and types of the lowest-free-ID allocator.
// No dependencies.
package lfid_pkg;

  localparam int CAPACITY_DEF    = 256;
  localparam int TREE_LEVELS_DEF = 9;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RESERVE = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_USED  = 3'd2;
  localparam logic [2:0] ST_FREE  = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  typedef struct packed {
    logic       valid;
    logic [2:0] status;
  } res_ctl_t;

endpackage

// ===== hdl/lfid_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lfid_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/lfid_seq.sv =====
// Sequencer of the allocator: clears the count tree, walks it down for an
// allocate and up for a count update. Depends on lfid_pkg.
module lfid_seq import lfid_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int TREE_LEVELS = TREE_LEVELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [1:0]             operation,
  input  logic [TREE_LEVELS-1:0] id,
  output logic                   busy,
  output logic                   ram_we,
  output logic [TREE_LEVELS-1:0] ram_waddr,
  output logic [TREE_LEVELS-1:0] ram_wdata,
  output logic [TREE_LEVELS-1:0] ram_raddr,
  input  logic [TREE_LEVELS-1:0] ram_rdata,
  output res_ctl_t               res,
  output logic [TREE_LEVELS-1:0] res_rid
);

  localparam int AW = TREE_LEVELS;
  localparam logic [AW-1:0] ROOT_NODE = AW'(1);
  localparam logic [AW-1:0] CAP       = AW'(CAPACITY);
  localparam logic [AW-1:0] HALF0     = AW'(CAPACITY / 2);
  localparam logic [AW-1:0] LEAF_OFS  = AW'(CAPACITY - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ROOT  = 6'b000100,
    S_DESC  = 6'b001000,
    S_CHK   = 6'b010000,
    S_UPD   = 6'b100000
  } state_t;

  state_t        state, state_next;
  logic [AW-1:0] node, node_next;
  logic [AW-1:0] half, half_next;
  logic [AW-1:0] rid, rid_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic          add, add_next;

  logic [AW-1:0] child;
  logic [AW-1:0] upd_val;
  logic [AW-1:0] leaf;
  logic          walk_up;

  assign busy    = (state != S_IDLE);
  assign child   = (ram_rdata < half) ? {node[AW-2:0], 1'b0} : {node[AW-2:0], 1'b1};
  assign leaf    = id + LEAF_OFS;
  // count +1 or -1 with floor at zero
  assign upd_val = add ? ram_rdata + AW'(1)
                       : ((ram_rdata != '0) ? ram_rdata - AW'(1) : ram_rdata);

  always_comb begin
    state_next    = state;
    node_next     = node;
    half_next     = half;
    rid_next      = rid;
    clr_addr_next = clr_addr;
    add_next      = add;
    ram_we        = 1'b0;
    ram_waddr     = node;
    ram_wdata     = upd_val;
    ram_raddr     = '0;
    res.valid     = 1'b0;
    res.status    = ST_OK;
    res_rid       = rid;
    walk_up       = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (&clr_addr) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          rid_next = id;
          add_next = (operation != OP_RELEASE);
          if (operation == OP_ALLOC) begin
            ram_raddr  = ROOT_NODE;
            state_next = S_ROOT;
          end else if (operation == OP_RESERVE || operation == OP_RELEASE) begin
            if (id == '0 || id > CAP) begin
              res.valid  = 1'b1;
              res.status = ST_RANGE;
              res_rid    = id;
            end else begin
              ram_raddr  = leaf;
              node_next  = leaf;
              state_next = S_CHK;
            end
          end else begin
            res.valid  = 1'b1;
            res.status = ST_RANGE;
            res_rid    = '0;
          end
        end
      end
      S_ROOT: begin
        if (ram_rdata >= CAP) begin
          res.valid  = 1'b1;
          res.status = ST_FULL;
          res_rid    = '0;
          state_next = S_IDLE;
        end else begin
          ram_raddr  = {ROOT_NODE[AW-2:0], 1'b0};
          node_next  = ROOT_NODE;
          half_next  = HALF0;
          state_next = S_DESC;
        end
      end
      S_DESC: begin
        node_next = child;
        if (child[AW-1]) begin
          ram_raddr  = child;
          rid_next   = {1'b0, child[AW-2:0]} + AW'(1);
          state_next = S_UPD;
        end else begin
          ram_raddr = {child[AW-2:0], 1'b0};
          half_next = half >> 1;
        end
      end
      S_CHK: begin
        if (add && ram_rdata != '0) begin
          res.valid  = 1'b1;
          res.status = ST_USED;
          state_next = S_IDLE;
        end else if (!add && ram_rdata == '0) begin
          res.valid  = 1'b1;
          res.status = ST_FREE;
          state_next = S_IDLE;
        end else begin
          walk_up = 1'b1;
        end
      end
      S_UPD: begin
        walk_up = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // write this node; read its parent unless this is the root
    if (walk_up) begin
      ram_we = 1'b1;
      if (node == ROOT_NODE) begin
        res.valid  = 1'b1;
        res.status = ST_OK;
        state_next = S_IDLE;
      end else begin
        ram_raddr  = node >> 1;
        node_next  = node >> 1;
        state_next = S_UPD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
    node <= node_next;
    half <= half_next;
    rid  <= rid_next;
    add  <= add_next;
  end

endmodule

// ===== hdl/lowest_free_id_allocator.sv =====
// Lowest-free-ID allocator: top level with count-tree RAM and result register.
// Depends on lfid_pkg, lfid_ram, lfid_seq and the assertion macro header.
// Allocate: root count checked, walk down to the lowest free leaf, then counts walked up.
// Reserve/release: leaf checked, counts walked up; range/unknown-op errors answer from idle.
// One request at a time: start is ignored while busy; busy falls as done rises.
// After reset busy is high while every entry of the tree RAM is cleared.
`include "lowest_free_id_allocator_macros.svh"

module lowest_free_id_allocator import lfid_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int TREE_LEVELS = TREE_LEVELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             operation,
  input  logic [TREE_LEVELS-1:0] id,
  output logic                   done,
  output logic [TREE_LEVELS-1:0] result_id,
  output logic [2:0]             status
);

  localparam int AW = TREE_LEVELS;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [AW-1:0] ram_rdata;
  res_ctl_t      res;
  logic [AW-1:0] res_rid;

  lfid_seq #(
    .CAPACITY    (CAPACITY),
    .TREE_LEVELS (TREE_LEVELS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .id        (id),
    .busy      (busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res       (res),
    .res_rid   (res_rid)
  );

  lfid_ram #(
    .WIDTH (AW),
    .DEPTH (2 * CAPACITY)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
    result_id <= res_rid;
    status    <= res.status;
  end

  `LFID_ASSERT_NXT(a_accept_progress, start && !busy, busy || done)
  `LFID_ASSERT_IMP(a_ok_has_id, done && status == ST_OK, result_id != '0)
  `LFID_ASSERT_IMP(a_full_no_id, done && status == ST_FULL, result_id == '0)
  `LFID_ASSERT_IMP(a_status_legal, done, status <= ST_RANGE)

endmodule
